// ===== rtl/csf_pkg.sv =====
// Shared constants, status codes and control types of the counting semaphore block.
`default_nettype none
package csf_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	localparam int THREAD_W    = 8;
	localparam int STATUS_W    = 3;
	localparam int INIT_W      = 16;
	localparam int COUNT_W     = 18;
	localparam int COUNT_OUT_W = 17;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 18'sd65535;
	localparam logic signed [COUNT_W-1:0] COUNT_ZERO = 18'sd0;
	localparam logic signed [COUNT_W-1:0] COUNT_ONE  = 18'sd1;

	localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BLOCKED    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_WAITER  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_WOKE       = 3'd3;
	localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;
	localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd5;

	localparam logic CMD_WAIT   = 1'b0;
	localparam logic CMD_SIGNAL = 1'b1;

	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} queue_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage
`default_nettype wire

// ===== rtl/csf_queue.sv =====
// Wait queue of thread identifiers held in a synchronous memory with its pointers.
`default_nettype none
module csf_queue #(
	parameter int QUEUE_DEPTH = csf_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = csf_pkg::ID_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire csf_pkg::queue_ctrl_t  ctrl,
	input  wire  [ID_BITS-1:0]         wr_id,
	output csf_pkg::queue_stat_t       stat,
	output logic [ID_BITS-1:0]         rd_id
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TOT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [TOT_W-1:0] FULL_TOTAL = TOT_W'(QUEUE_DEPTH);

	logic [ID_BITS-1:0] mem [QUEUE_DEPTH];
	logic [PTR_W-1:0]   head_q;
	logic [PTR_W-1:0]   tail_q;
	logic [TOT_W-1:0]   total_q;
	logic [ID_BITS-1:0] rd_q;

	function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
		next_slot = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
		end else if (ctrl.clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			total_q <= '0;
		end else if (ctrl.push) begin
			tail_q  <= next_slot(tail_q);
			total_q <= total_q + TOT_W'(1);
		end else if (ctrl.pop) begin
			head_q  <= next_slot(head_q);
			total_q <= total_q - TOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.push && !ctrl.clear) begin
			mem[tail_q] <= wr_id;
		end
		if (ctrl.pop) begin
			rd_q <= mem[head_q];
		end
	end

	assign stat.full  = (total_q == FULL_TOTAL);
	assign stat.empty = (total_q == '0);
	assign rd_id      = rd_q;

endmodule
`default_nettype wire

// ===== rtl/counting_semaphore_fifo_top.sv =====
// Top level of the counting semaphore with its queue of waiting threads.
// A wait, a grant or a signal without a waiter gives its result in the cycle after the beat.
// A signal that wakes a waiter reads the queue memory; the read state then registers the result.
// One command is in flight at a time: one beat per cycle unless stalled or reading the queue.
// Reset clears the count, the queue pointers and the output valid flag; the memory is not cleared.
`default_nettype none
module counting_semaphore_fifo_top #(
	parameter int QUEUE_DEPTH = csf_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = csf_pkg::ID_BITS_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      cfg_we,
	input  wire  [csf_pkg::INIT_W-1:0]               cfg_wdata,
	input  wire                                      in_valid,
	output logic                                     in_ready,
	input  wire                                      command,
	input  wire  [csf_pkg::THREAD_W-1:0]             thread_id,
	output logic                                     out_valid,
	input  wire                                      out_ready,
	output logic [csf_pkg::STATUS_W-1:0]             status,
	output logic [csf_pkg::THREAD_W-1:0]             woken_thread,
	output logic signed [csf_pkg::COUNT_OUT_W-1:0]   count_after
);

	localparam int EXT_W = (ID_BITS > csf_pkg::THREAD_W) ? ID_BITS : csf_pkg::THREAD_W;
	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic                                  state_q;
	logic signed [csf_pkg::COUNT_W-1:0]    count_q;
	logic                                  out_valid_q;
	logic [csf_pkg::STATUS_W-1:0]          out_status_q;
	logic [csf_pkg::THREAD_W-1:0]          out_woken_q;
	logic signed [csf_pkg::COUNT_OUT_W-1:0] out_count_q;

	csf_pkg::queue_ctrl_t                  qctrl;
	csf_pkg::queue_stat_t                  qstat;
	logic [ID_BITS-1:0]                    rd_id;
	logic [EXT_W-1:0]                      tid_ext;
	logic [EXT_W-1:0]                      rd_ext;

	logic                                  accept;
	logic signed [csf_pkg::COUNT_W-1:0]    count_dec;
	logic signed [csf_pkg::COUNT_W-1:0]    count_inc;
	logic signed [csf_pkg::COUNT_W-1:0]    count_nxt;
	logic [csf_pkg::STATUS_W-1:0]          status_nxt;
	logic                                  push;
	logic                                  pop;

	assign in_ready = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign count_dec = count_q - csf_pkg::COUNT_ONE;
	assign count_inc = count_q + csf_pkg::COUNT_ONE;
	assign tid_ext   = EXT_W'(thread_id);
	assign rd_ext    = EXT_W'(rd_id);

	always_comb begin
		count_nxt  = count_q;
		status_nxt = csf_pkg::ST_GRANTED;
		push       = 1'b0;
		pop        = 1'b0;
		unique case (command)
			csf_pkg::CMD_WAIT: begin
				if (count_dec < csf_pkg::COUNT_ZERO) begin
					if (qstat.full) begin
						status_nxt = csf_pkg::ST_QUEUE_FULL;
					end else begin
						push       = 1'b1;
						count_nxt  = count_dec;
						status_nxt = csf_pkg::ST_BLOCKED;
					end
				end else begin
					count_nxt  = count_dec;
					status_nxt = csf_pkg::ST_GRANTED;
				end
			end
			csf_pkg::CMD_SIGNAL: begin
				if (count_q >= csf_pkg::COUNT_MAX) begin
					count_nxt  = csf_pkg::COUNT_MAX;
					status_nxt = csf_pkg::ST_SATURATED;
				end else begin
					count_nxt = count_inc;
					if (count_inc <= csf_pkg::COUNT_ZERO && !qstat.empty) begin
						pop        = 1'b1;
						status_nxt = csf_pkg::ST_WOKE;
					end else begin
						status_nxt = csf_pkg::ST_NO_WAITER;
					end
				end
			end
			default: begin
				status_nxt = csf_pkg::ST_GRANTED;
			end
		endcase
	end

	assign qctrl.push  = accept && push;
	assign qctrl.pop   = accept && pop;
	assign qctrl.clear = cfg_we;

	csf_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_BITS     (ID_BITS)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (qctrl),
		.wr_id  (tid_ext[ID_BITS-1:0]),
		.stat   (qstat),
		.rd_id  (rd_id)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_we) begin
			count_q <= $signed({{(csf_pkg::COUNT_W - csf_pkg::INIT_W){1'b0}}, cfg_wdata});
		end else if (accept) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_valid_q <= !pop;
						state_q     <= pop ? S_READ : S_IDLE;
					end else if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_status_q <= status_nxt;
			out_woken_q  <= '0;
			out_count_q  <= count_nxt[csf_pkg::COUNT_OUT_W-1:0];
		end else if (state_q == S_READ) begin
			out_woken_q <= rd_ext[csf_pkg::THREAD_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign woken_thread = out_woken_q;
	assign count_after  = out_count_q;

endmodule
`default_nettype wire

// ===== rtl/csf_checker.sv =====
// Port-level checks of the counting semaphore block and their binding to the top level.
`default_nettype none
module csf_checker (
	input wire                                    clk,
	input wire                                    arst_n,
	input wire                                    out_valid,
	input wire                                    out_ready,
	input wire [csf_pkg::STATUS_W-1:0]            status,
	input wire [csf_pkg::THREAD_W-1:0]            woken_thread,
	input wire [csf_pkg::COUNT_OUT_W-1:0]         count_after
);

	localparam logic [csf_pkg::COUNT_OUT_W-1:0] OUT_MAX =
		csf_pkg::COUNT_MAX[csf_pkg::COUNT_OUT_W-1:0];

	// A stalled result beat stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// Only a wake reports a thread identifier.
	a_woken_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != csf_pkg::ST_WOKE |-> woken_thread == '0)
		else $error("woken thread reported without a wake");

	// A grant leaves the count at zero or above.
	a_grant_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == csf_pkg::ST_GRANTED |-> !count_after[csf_pkg::COUNT_OUT_W-1])
		else $error("grant left a negative count");

	// A blocked caller leaves a negative count.
	a_block_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == csf_pkg::ST_BLOCKED |-> count_after[csf_pkg::COUNT_OUT_W-1])
		else $error("blocked caller with a non-negative count");

	// Saturation always reports the maximum count.
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == csf_pkg::ST_SATURATED |-> count_after == OUT_MAX)
		else $error("saturated count is not the maximum");

endmodule

bind counting_semaphore_fifo_top csf_checker u_csf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.woken_thread (woken_thread),
	.count_after  (count_after)
);
`default_nettype wire

// ===== tb/sv/counting_semaphore_fifo_checker.sv =====
// Checker that predicts every result of the counting semaphore and compares the result beats.
module counting_semaphore_fifo_checker (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    cfg_we,
	input  wire  [csf_pkg::INIT_W-1:0]             cfg_wdata,
	input  wire                                    in_valid,
	input  wire                                    in_ready,
	input  wire                                    command,
	input  wire  [csf_pkg::THREAD_W-1:0]           thread_id,
	input  wire                                    out_valid,
	input  wire                                    out_ready,
	input  wire  [csf_pkg::STATUS_W-1:0]           status,
	input  wire  [csf_pkg::THREAD_W-1:0]           woken_thread,
	input  wire  signed [csf_pkg::COUNT_OUT_W-1:0] count_after,
	output int                                     outstanding,
	output int                                     fail_count
);

	typedef struct packed {
		logic [csf_pkg::STATUS_W-1:0]    status;
		logic [csf_pkg::THREAD_W-1:0]    woken;
		logic [csf_pkg::COUNT_OUT_W-1:0] count;
	} sem_result_t;

	logic signed [csf_pkg::COUNT_W-1:0] sem_count;
	logic [csf_pkg::INIT_W-1:0]         reload_value;
	logic [csf_pkg::THREAD_W-1:0]       wait_ring [csf_pkg::QUEUE_DEPTH_DEF];
	int                                 ring_head;
	int                                 ring_tail;
	int                                 waiters;
	sem_result_t                        result_q [$];
	int                                 mismatches = 0;

	assign fail_count = mismatches;

	task automatic report_mismatch(input string what);
		$display("%0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic reload_semaphore();
		sem_count = $signed({2'b00, reload_value});
		ring_head = 0;
		ring_tail = 0;
		waiters   = 0;
	endtask

	task automatic predict_command(input logic cmd, input logic [csf_pkg::THREAD_W-1:0] tid,
			output sem_result_t res);
		logic [csf_pkg::THREAD_W-1:0] kept;
		kept = tid & csf_pkg::THREAD_W'((1 << csf_pkg::ID_BITS_DEF) - 1);
		res = '0;
		if (cmd == csf_pkg::CMD_WAIT) begin
			if (sem_count <= csf_pkg::COUNT_ZERO) begin
				if (waiters >= csf_pkg::QUEUE_DEPTH_DEF) begin
					res.status = csf_pkg::ST_QUEUE_FULL;
				end else begin
					wait_ring[ring_tail] = kept;
					ring_tail = (ring_tail + 1) % csf_pkg::QUEUE_DEPTH_DEF;
					waiters++;
					sem_count = sem_count - csf_pkg::COUNT_ONE;
					res.status = csf_pkg::ST_BLOCKED;
				end
			end else begin
				sem_count = sem_count - csf_pkg::COUNT_ONE;
				res.status = csf_pkg::ST_GRANTED;
			end
		end else if (sem_count >= csf_pkg::COUNT_MAX) begin
			sem_count = csf_pkg::COUNT_MAX;
			res.status = csf_pkg::ST_SATURATED;
		end else begin
			sem_count = sem_count + csf_pkg::COUNT_ONE;
			if (sem_count <= csf_pkg::COUNT_ZERO && waiters > 0) begin
				res.woken = wait_ring[ring_head];
				ring_head = (ring_head + 1) % csf_pkg::QUEUE_DEPTH_DEF;
				waiters--;
				res.status = csf_pkg::ST_WOKE;
			end else begin
				res.status = csf_pkg::ST_NO_WAITER;
			end
		end
		res.count = sem_count[csf_pkg::COUNT_OUT_W-1:0];
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		sem_result_t want;
		sem_result_t fresh;
		if (!arst_n) begin
			reload_value = '0;
			reload_semaphore();
			result_q.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (result_q.size() == 0) begin
					report_mismatch($sformatf("result beat with no command pending, status %0d",
						status));
				end else begin
					want = result_q.pop_front();
					if (status !== want.status) begin
						report_mismatch($sformatf("status got %0d expected %0d",
							status, want.status));
					end
					if (woken_thread !== want.woken) begin
						report_mismatch($sformatf("woken_thread got %0h expected %0h",
							woken_thread, want.woken));
					end
					if (count_after !== want.count) begin
						report_mismatch($sformatf("count_after got %0d expected %0d",
							count_after, $signed(want.count)));
					end
				end
			end
			if (cfg_we) begin
				reload_value = cfg_wdata;
				reload_semaphore();
			end
			if (in_valid && in_ready) begin
				predict_command(command, thread_id, fresh);
				result_q.push_back(fresh);
			end
			outstanding <= result_q.size();
		end
	end

endmodule

// ===== tb/sv/counting_semaphore_fifo_top_tb.sv =====
// Testbench top of the counting semaphore: drives commands and register writes, gives the verdict.
module counting_semaphore_fifo_top_tb;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_START  = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 210;

	typedef enum {RX_FREE, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [csf_pkg::INIT_W-1:0]      cfg_wdata = '0;
	logic                            in_valid  = 1'b0;
	logic                            command   = csf_pkg::CMD_WAIT;
	logic [csf_pkg::THREAD_W-1:0]    thread_id = '0;
	logic                            out_ready = 1'b0;
	wire                             in_ready;
	wire                             out_valid;
	wire [csf_pkg::STATUS_W-1:0]     status;
	wire [csf_pkg::THREAD_W-1:0]     woken_thread;
	wire signed [csf_pkg::COUNT_OUT_W-1:0] count_after;
	int                              outstanding;
	int                              fail_count;

	always #5 clk = ~clk;

	counting_semaphore_fifo_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.thread_id    (thread_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.woken_thread (woken_thread),
		.count_after  (count_after)
	);

	counting_semaphore_fifo_checker sem_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.thread_id    (thread_id),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.woken_thread (woken_thread),
		.count_after  (count_after),
		.outstanding  (outstanding),
		.fail_count   (fail_count)
	);

	task automatic send_cmd(input logic cmd, input logic [csf_pkg::THREAD_W-1:0] tid);
		in_valid  <= 1'b1;
		command   <= cmd;
		thread_id <= tid;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_initial(input logic [csf_pkg::INIT_W-1:0] value);
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : receiver
		int       cyc;
		rx_mode_t rx_mode;
		cyc = 0;
		rx_mode = RX_FREE;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 64 == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			end
			if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FREE:     out_ready <= 1'b1;
					RX_HALF:     out_ready <= $urandom_range(0, 1) != 0;
					RX_SPARSE:   out_ready <= $urandom_range(0, 3) == 0;
					RX_PERIODIC: out_ready <= (cyc % 3) != 0;
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("counting_semaphore_fifo_top test failed");
		$finish;
	end

	initial begin : stimulus
		logic [csf_pkg::INIT_W-1:0]   phase_init [PHASES];
		logic [csf_pkg::THREAD_W-1:0] tid;
		logic                         cmd;
		int                           i;
		int                           p;
		int                           sent;
		int                           burst;
		int                           gap;
		int                           bias;
		phase_init[0] = 16'd0;
		phase_init[1] = 16'hFFFF;
		phase_init[2] = 16'd1;
		phase_init[3] = csf_pkg::INIT_W'($urandom_range(0, 20));
		phase_init[4] = 16'hFFFA;
		phase_init[5] = csf_pkg::INIT_W'($urandom);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Fill the wait queue, overflow it once, then wake the two oldest waiters.
		load_initial(16'd0);
		for (i = 0; i < csf_pkg::QUEUE_DEPTH_DEF; i++) begin
			tid = (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : (i == 2) ? 8'hAA :
				(i == 3) ? 8'h55 : csf_pkg::THREAD_W'($urandom);
			send_cmd(csf_pkg::CMD_WAIT, tid);
		end
		send_cmd(csf_pkg::CMD_WAIT, 8'h5A);
		send_cmd(csf_pkg::CMD_SIGNAL, 8'hFF);
		send_cmd(csf_pkg::CMD_SIGNAL, 8'h00);

		// At the top of the range a signal saturates.
		load_initial(16'hFFFF);
		send_cmd(csf_pkg::CMD_SIGNAL, 8'h01);
		send_cmd(csf_pkg::CMD_WAIT, 8'hFE);
		send_cmd(csf_pkg::CMD_SIGNAL, 8'h80);
		send_cmd(csf_pkg::CMD_SIGNAL, 8'h7F);

		for (p = 0; p < PHASES; p++) begin
			load_initial(phase_init[p]);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				burst = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
				case ($urandom_range(0, 2))
					0:       bias = 25;
					1:       bias = 50;
					default: bias = 75;
				endcase
				for (i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
					cmd = ($urandom_range(0, 99) < bias) ? csf_pkg::CMD_SIGNAL
						: csf_pkg::CMD_WAIT;
					send_cmd(cmd, csf_pkg::THREAD_W'($urandom));
					sent++;
				end
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("counting_semaphore_fifo_top test passed");
		end else begin
			$display("counting_semaphore_fifo_top test failed");
		end
		$finish;
	end

endmodule

// ===== counting_semaphore_fifo_top.f =====
rtl/csf_pkg.sv
rtl/csf_queue.sv
rtl/counting_semaphore_fifo_top.sv
rtl/csf_checker.sv
tb/sv/counting_semaphore_fifo_checker.sv
tb/sv/counting_semaphore_fifo_top_tb.sv
